// ===== rtl/magnetometer_set_reset_offset_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the set/reset offset tracker
// Clocked implication checks with a synchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef MAGNETOMETER_SET_RESET_OFFSET_TRACKER_MACROS_SVH
`define MAGNETOMETER_SET_RESET_OFFSET_TRACKER_MACROS_SVH

// Same-cycle implication
`define MSROT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msrot assertion failed");

// Next-cycle implication
`define MSROT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msrot assertion failed");

`endif

// ===== rtl/msrot_pkg.sv =====
// ----------------------------------------------------------------------------
// msrot_pkg
// Shared types and constants of the magnetometer set/reset offset tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msrot_pkg;

    // Fraction bits of the offset estimate (Q16.FRAC)
    localparam int FRAC_BITS_DEF = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SHIFT = 1'd1;

    localparam logic [7:0] CAL_INTERVAL_RST = 8'd20;
    localparam logic [2:0] FILTER_SHIFT_RST = 3'd2;

    // Attempt counter
    localparam int          CNT_W   = 9;
    localparam logic [8:0]  CNT_MAX = 9'd511;

    typedef struct packed {
        logic        status_ok;
        logic        meas_done;
        logic        data_ok;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [15:0] raw_z;
        logic [15:0] set_x;
        logic [15:0] set_y;
        logic [15:0] set_z;
    } t_in_word;

    typedef struct packed {
        logic               valid_res;
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
        logic               cal_done;
    } t_out_word;

    typedef struct packed {
        logic [7:0] cal_interval;
        logic [2:0] filter_shift;
    } t_cfg;

endpackage

// ===== rtl/msrot_cfg.sv =====
// ----------------------------------------------------------------------------
// msrot_cfg
// Configuration registers: calibration interval and offset filter shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msrot_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [msrot_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [msrot_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output msrot_pkg::t_cfg                      o_cfg
);
    import msrot_pkg::*;

    t_cfg r_cfg;

    // Write the addressed register, drop unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal_interval <= CAL_INTERVAL_RST;
            r_cfg.filter_shift <= FILTER_SHIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CAL_INTERVAL: r_cfg.cal_interval <= i_cfg_data[7:0];
                CFG_FILTER_SHIFT: r_cfg.filter_shift <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/msrot_axis.sv =====
// ----------------------------------------------------------------------------
// msrot_axis
// One axis: offset estimate update on calibration and corrected output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msrot_axis #(
    parameter int FRAC_BITS = msrot_pkg::FRAC_BITS_DEF
) (
    input  logic [15:0]                i_raw,
    input  logic [15:0]                i_set,
    input  logic signed [FRAC_BITS+15:0] i_est,
    input  logic                       i_cal,
    input  logic [2:0]                 i_shift,
    output logic signed [FRAC_BITS+15:0] o_est,
    output logic signed [15:0]         o_mag
);
    localparam int EST_W = FRAC_BITS + 16;

    logic signed [15:0]      s;
    logic signed [15:0]      t;
    logic signed [16:0]      diff;
    logic signed [EST_W-1:0] half;
    logic signed [EST_W:0]   delta;
    logic signed [EST_W:0]   step;
    logic signed [EST_W+1:0] upd;
    logic signed [EST_W-1:0] upd_sat;
    logic signed [EST_W-1:0] est_use;
    logic signed [EST_W:0]   sum;
    logic signed [EST_W:0]   rnd;
    logic signed [16:0]      q;

    always_comb begin
        // Re-center offset binary counts
        s = $signed({~i_raw[15], i_raw[14:0]});
        t = $signed({~i_set[15], i_set[14:0]});

        // Half of set minus normal, in estimate format
        diff  = $signed({t[15], t}) - $signed({s[15], s});
        half  = $signed({diff, {(FRAC_BITS-1){1'b0}}});

        // First-order filter step, floor division by arithmetic shift
        delta = $signed({half[EST_W-1], half}) - $signed({i_est[EST_W-1], i_est});
        step  = delta >>> i_shift;
        upd   = $signed({{2{i_est[EST_W-1]}}, i_est}) + $signed({step[EST_W], step});

        // Clamp the update to the estimate format
        if (upd[EST_W+1] != upd[EST_W] || upd[EST_W] != upd[EST_W-1]) begin
            upd_sat = upd[EST_W+1] ? $signed({1'b1, {(EST_W-1){1'b0}}})
                                   : $signed({1'b0, {(EST_W-1){1'b1}}});
        end else begin
            upd_sat = upd[EST_W-1:0];
        end

        est_use = i_cal ? upd_sat : i_est;

        // Sample plus estimate, truncate toward zero
        sum = $signed({s[15], s, {FRAC_BITS{1'b0}}})
            + $signed({est_use[EST_W-1], est_use});
        rnd = sum[EST_W] ? sum + $signed({{(EST_W+1-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}})
                         : sum;
        q   = rnd[EST_W:FRAC_BITS];

        // Saturate to int16
        if (q[16] != q[15]) begin
            o_mag = q[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            o_mag = q[15:0];
        end

        o_est = est_use;
    end

endmodule

// ===== rtl/magnetometer_set_reset_offset_tracker.sv =====
// A word in the input register moves to the result register when the result
// stage is free. Throughput: one word per cycle while i_out_stall stays low;
// the single-pass datapath sits between them, and stalls pass back one stage.
// Reset (i_rst_n low, synchronous): both stages empty, attempt counter and
// offset estimates zero, cal_interval 20, filter_shift 2.
// ----------------------------------------------------------------------------
// magnetometer_set_reset_offset_tracker
// Set/reset offset tracker: counts read attempts, periodically refines the
// per-axis offset estimates and outputs corrected, saturated field samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "magnetometer_set_reset_offset_tracker_macros.svh"

module magnetometer_set_reset_offset_tracker #(
    parameter int FRAC_BITS = msrot_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  msrot_pkg::t_in_word               i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output msrot_pkg::t_out_word              o_out_word,
    input  logic                              i_cfg_we,
    input  logic [msrot_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [msrot_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import msrot_pkg::*;

    localparam int EST_W = FRAC_BITS + 16;

    t_cfg                    cfg;
    logic                    r_in_valid;
    t_in_word                r_in_word;
    logic                    r_out_valid;
    t_out_word               r_out_word;
    logic [CNT_W-1:0]        r_cnt;
    logic [CNT_W-1:0]        cnt_inc;
    logic [CNT_W-1:0]        n_cnt;
    logic signed [EST_W-1:0] r_est_x;
    logic signed [EST_W-1:0] r_est_y;
    logic signed [EST_W-1:0] r_est_z;
    logic signed [EST_W-1:0] n_est_x;
    logic signed [EST_W-1:0] n_est_y;
    logic signed [EST_W-1:0] n_est_z;
    logic signed [15:0]      mag_x;
    logic signed [15:0]      mag_y;
    logic signed [15:0]      mag_z;
    logic                    good;
    logic                    cal;
    logic                    advance;
    logic                    accept_in;
    t_out_word               n_out_word;

    msrot_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Handshake: the input stage moves on when the result stage is free
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept_in  = i_in_valid && !o_in_stall;

    // Attempt counter with saturation, calibration decision
    always_comb begin
        good    = r_in_word.status_ok && r_in_word.meas_done && r_in_word.data_ok;
        cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 1'b1;
        cal     = good && (cnt_inc > {1'b0, cfg.cal_interval});
        n_cnt   = cal ? '0 : cnt_inc;
    end

    msrot_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
        .i_raw   (r_in_word.raw_x),
        .i_set   (r_in_word.set_x),
        .i_est   (r_est_x),
        .i_cal   (cal),
        .i_shift (cfg.filter_shift),
        .o_est   (n_est_x),
        .o_mag   (mag_x)
    );

    msrot_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
        .i_raw   (r_in_word.raw_y),
        .i_set   (r_in_word.set_y),
        .i_est   (r_est_y),
        .i_cal   (cal),
        .i_shift (cfg.filter_shift),
        .o_est   (n_est_y),
        .o_mag   (mag_y)
    );

    msrot_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
        .i_raw   (r_in_word.raw_z),
        .i_set   (r_in_word.set_z),
        .i_est   (r_est_z),
        .i_cal   (cal),
        .i_shift (cfg.filter_shift),
        .o_est   (n_est_z),
        .o_mag   (mag_z)
    );

    // Build the result word, zero on a failed read
    always_comb begin
        n_out_word.valid_res = good;
        n_out_word.mag_x     = good ? mag_x : '0;
        n_out_word.mag_y     = good ? mag_y : '0;
        n_out_word.mag_z     = good ? mag_z : '0;
        n_out_word.cal_done  = cal;
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_est_x     <= '0;
            r_est_y     <= '0;
            r_est_z     <= '0;
        end else begin
            r_in_valid  <= accept_in || (r_in_valid && !advance);
            r_out_valid <= advance || (r_out_valid && i_out_stall);
            if (advance) begin
                r_cnt   <= n_cnt;
                r_est_x <= n_est_x;
                r_est_y <= n_est_y;
                r_est_z <= n_est_z;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `MSROT_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, r_out_valid && !r_out_word.valid_res, r_out_word.mag_x == 16'sd0 && r_out_word.mag_y == 16'sd0 && r_out_word.mag_z == 16'sd0 && !r_out_word.cal_done)
    `MSROT_ASSERT_NOW(a_cal_needs_good, i_clk, i_rst_n, r_out_valid && r_out_word.cal_done, r_out_word.valid_res)
    `MSROT_ASSERT_NEXT(a_cal_clears_cnt, i_clk, i_rst_n, advance && cal, r_cnt == '0)
    `MSROT_ASSERT_NEXT(a_est_hold, i_clk, i_rst_n, !advance, $stable(r_est_x) && $stable(r_est_y) && $stable(r_est_z))
    `MSROT_ASSERT_NOW(a_full_stall, i_clk, i_rst_n, r_in_valid && r_out_valid && i_out_stall, o_in_stall)

endmodule

// ===== tb/magnetometer_set_reset_offset_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_set_reset_offset_tracker_tb
// Self-checking bench for the set/reset offset tracker. A table of directed
// read attempts covers the field extremes, every failed-read flag pattern and
// the first calibration. Random phases follow under several register
// settings: a calibrate-on-every-good-read phase, a long run of failed reads that
// drives the attempt counter into saturation, and a mid-range phase. A
// bit-accurate tracker model in the bench predicts every output word. The
// sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------

module magnetometer_set_reset_offset_tracker_tb;

    import msrot_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;

    // Offset estimate limits, Q16.FRAC
    localparam longint EST_HI = (longint'(1) << (15 + FRAC)) - 1;
    localparam longint EST_LO = -(longint'(1) << (15 + FRAC));

    // One directed attempt; the expected word is used only when typed is set
    typedef struct packed {
        logic [2:0]         flags;
        logic [15:0]        raw_x, raw_y, raw_z;
        logic [15:0]        set_x, set_y, set_z;
        logic               typed;
        logic               exp_valid;
        logic signed [15:0] exp_x, exp_y, exp_z;
        logic               exp_cal;
    } t_attempt_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_in_word               i_in_word = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_word              o_out_word;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Tracker model state and its copy of the registers
    logic [CNT_W-1:0]       attempt_count;
    longint                 offset_est [3];
    logic [7:0]             cfg_cal_interval;
    logic [2:0]             cfg_filter_shift;

    t_out_word              pending_samples [$];

    int                     mismatch_count = 0;
    int                     attempts_sent = 0;
    int                     good_reads_sent = 0;
    int                     words_checked = 0;
    int                     calibrations_seen = 0;
    int                     burst_left = 8;

    // Receiver stall pattern
    int                     stall_mode = 0;
    int                     stall_left = 0;
    int unsigned            cycle_count = 0;

    t_attempt_row attempt_table [24] = '{
        '{3'b111, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
          1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b111, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF, 16'h0001,
          1'b1, 1'b1, 16'sh8000, 16'sd32767, -16'sd32767, 1'b0},
        '{3'b011, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b101, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h1357, 16'h2468,
          1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b110, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
          1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
          1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b001, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
          1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b010, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
          1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b100, 16'h0F0F, 16'hF0F0, 16'h0F0F, 16'hF0F0, 16'h0F0F, 16'hF0F0,
          1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b111, 16'h1234, 16'hABCD, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
          1'b1, 1'b1, -16'sd28108, 16'sd11213, -16'sd1, 1'b0},
        '{3'b111, 16'hFFFF, 16'h0000, 16'h8001, 16'h0000, 16'hFFFF, 16'h5555,
          1'b1, 1'b1, 16'sd32767, 16'sh8000, 16'sd1, 1'b0},
        '{3'b111, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hAAAA, 16'h5555, 16'hF0F0,
          1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b111, 16'hF0F0, 16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00, 16'h0F0F,
          1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b111, 16'h3333, 16'hCCCC, 16'h6666, 16'hCCCC, 16'h3333, 16'h9999,
          1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b111, 16'h9999, 16'h6666, 16'hC3C3, 16'h3C3C, 16'hC3C3, 16'h6666,
          1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b111, 16'h7FFF, 16'h8000, 16'h8001, 16'h8001, 16'h7FFF, 16'h8000,
          1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b011, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b111, 16'h4000, 16'hC000, 16'h2000, 16'hE000, 16'h1000, 16'hA000,
          1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b111, 16'h0001, 16'hFFFE, 16'h8888, 16'hFFFE, 16'h0001, 16'h7777,
          1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        // Counter reaches the default interval but does not exceed it
        '{3'b111, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
          1'b1, 1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        // Counter past the interval, but a failed read never calibrates
        '{3'b110, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF,
          1'b1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        // First calibration: full-scale positive, negative and fractional offsets
        '{3'b111, 16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h8003,
          1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        // Corrected output saturates and truncates toward zero
        '{3'b111, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h1111, 16'h2222, 16'h3333,
          1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0},
        '{3'b111, 16'h0000, 16'hFFFF, 16'h8000, 16'h1111, 16'h2222, 16'h3333,
          1'b0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0}
    };

    magnetometer_set_reset_offset_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Move one axis estimate toward half the set-minus-normal difference
    function automatic longint refine_offset(longint est, longint s, longint t,
                                             logic [2:0] shift);
        longint half;
        longint next;
        half = (t - s) * (longint'(1) << (FRAC - 1));
        next = est + ((half - est) >>> shift);
        if (next > EST_HI) next = EST_HI;
        if (next < EST_LO) next = EST_LO;
        return next;
    endfunction

    // Add the estimate, truncate toward zero, saturate to int16
    function automatic logic [15:0] corrected_field(longint s, longint est);
        longint sum;
        longint q;
        sum = s * (longint'(1) << FRAC) + est;
        if (sum >= 0) q = sum >>> FRAC;
        else q = -((-sum) >>> FRAC);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    // Advance the tracker model by one read attempt and return its output word
    function automatic t_out_word track_attempt(t_in_word w);
        t_out_word res;
        longint    s [3];
        longint    t [3];
        logic      good;
        good = w.status_ok & w.meas_done & w.data_ok;
        s[0] = longint'(w.raw_x) - 32768;
        s[1] = longint'(w.raw_y) - 32768;
        s[2] = longint'(w.raw_z) - 32768;
        t[0] = longint'(w.set_x) - 32768;
        t[1] = longint'(w.set_y) - 32768;
        t[2] = longint'(w.set_z) - 32768;
        res = '0;
        if (attempt_count < CNT_MAX) attempt_count = attempt_count + 1'b1;
        if (!good) return res;
        if (attempt_count > {1'b0, cfg_cal_interval}) begin
            attempt_count = '0;
            res.cal_done = 1'b1;
            for (int a = 0; a < 3; a++)
                offset_est[a] = refine_offset(offset_est[a], s[a], t[a], cfg_filter_shift);
        end
        res.valid_res = 1'b1;
        res.mag_x = corrected_field(s[0], offset_est[0]);
        res.mag_y = corrected_field(s[1], offset_est[1]);
        res.mag_z = corrected_field(s[2], offset_est[2]);
        return res;
    endfunction

    // Half full-scale or near-center counts, the rest uniform
    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'(32'h8000 + $urandom_range(0, 4095) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_word pick_attempt(int good_pct);
        t_in_word w;
        logic [2:0] flags;
        if ($urandom_range(0, 99) < good_pct) flags = 3'b111;
        else flags = 3'($urandom_range(0, 6));
        {w.status_ok, w.meas_done, w.data_ok} = flags;
        w.raw_x = pick_count();
        w.raw_y = pick_count();
        w.raw_z = pick_count();
        // Set reading half the time a small step off the normal one
        if ($urandom_range(0, 1) == 0) begin
            w.set_x = w.raw_x + 16'($urandom_range(0, 800)) - 16'd400;
            w.set_y = w.raw_y + 16'($urandom_range(0, 800)) - 16'd400;
            w.set_z = w.raw_z + 16'($urandom_range(0, 800)) - 16'd400;
        end else begin
            w.set_x = pick_count();
            w.set_y = pick_count();
            w.set_z = pick_count();
        end
        return w;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, longint got, longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Offer one word, hold it until accepted, then log its expected output
    task automatic drive_attempt(t_in_word w, logic typed, t_out_word typed_word);
        t_out_word predicted;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        predicted = track_attempt(w);
        pending_samples.push_back(typed ? typed_word : predicted);
        attempts_sent++;
        if (w.status_ok & w.meas_done & w.data_ok) good_reads_sent++;
        // End of burst: gap, or now and then hold off until all words are back
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            i_in_valid <= 1'b0;
            if ($urandom_range(0, 14) == 0)
                while (pending_samples.size() != 0) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic run_attempts(int count, int good_pct);
        for (int n = 0; n < count; n++)
            drive_attempt(pick_attempt(good_pct), 1'b0, '0);
    endtask

    // Stop sending and wait for every expected word
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_samples.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // Write both registers on back-to-back edges
    task automatic reconfigure(logic [7:0] interval, logic [CFG_DATA_W-1:0] shift_data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CAL_INTERVAL;
        i_cfg_data <= interval;
        @(posedge i_clk);
        cfg_cal_interval = interval;
        i_cfg_idx  <= CFG_FILTER_SHIFT;
        i_cfg_data <= shift_data;
        @(posedge i_clk);
        cfg_filter_shift = shift_data[2:0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver stall: free, light random, heavy random or periodic stretches
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 150);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 30);
            2: i_out_stall <= ($urandom_range(0, 99) < 75);
            default: i_out_stall <= cycle_count[2];
        endcase
    end

    // Compare each accepted output word with the oldest expectation
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("output word with nothing expected");
            end else begin
                want = pending_samples.pop_front();
                check_field("valid_res", o_out_word.valid_res, want.valid_res);
                check_field("mag_x", o_out_word.mag_x, want.mag_x);
                check_field("mag_y", o_out_word.mag_y, want.mag_y);
                check_field("mag_z", o_out_word.mag_z, want.mag_z);
                check_field("cal_done", o_out_word.cal_done, want.cal_done);
                words_checked++;
                if (o_out_word.cal_done) calibrations_seen++;
            end
        end
    end

    initial begin
        t_in_word     w;
        t_out_word    typed_word;
        t_attempt_row row;

        attempt_count    = '0;
        offset_est       = '{0, 0, 0};
        cfg_cal_interval = CAL_INTERVAL_RST;
        cfg_filter_shift = FILTER_SHIFT_RST;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed attempts under the reset register values
        foreach (attempt_table[r]) begin
            row = attempt_table[r];
            {w.status_ok, w.meas_done, w.data_ok} = row.flags;
            w.raw_x = row.raw_x;
            w.raw_y = row.raw_y;
            w.raw_z = row.raw_z;
            w.set_x = row.set_x;
            w.set_y = row.set_y;
            w.set_z = row.set_z;
            typed_word = '{row.exp_valid, row.exp_x, row.exp_y, row.exp_z, row.exp_cal};
            drive_attempt(w, row.typed, typed_word);
        end
        drain_outputs();

        // Calibrate on every good read, unity filter gain; upper data bits set
        reconfigure(8'd0, 8'hF8);
        run_attempts(100, 85);
        drain_outputs();

        // Longest interval, slowest filter: a failed-read run saturates the counter
        reconfigure(8'd255, 8'hFF);
        run_attempts(520, 0);
        run_attempts(40, 80);
        drain_outputs();

        // Mid-range interval and gain
        reconfigure(8'($urandom_range(1, 30)), 8'($urandom_range(1, 6)) | 8'h48);
        run_attempts(100, 85);
        drain_outputs();
        repeat (4) @(posedge i_clk);

        if (pending_samples.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived",
                                      pending_samples.size()));

        $display("Covered %0d read attempts (%0d good, %0d failed), %0d words checked,",
                 attempts_sent, good_reads_sent, attempts_sent - good_reads_sent,
                 words_checked);
        $display("%0d calibrations across intervals 0 to 255 and filter shifts 0 to 7.",
                 calibrations_seen);
        if (mismatch_count == 0) begin
            $display("magnetometer_set_reset_offset_tracker_tb: PASS");
        end else begin
            $display("magnetometer_set_reset_offset_tracker_tb: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Timeout with %0d words still expected", pending_samples.size());
        $display("magnetometer_set_reset_offset_tracker_tb: FAIL");
        $finish;
    end

endmodule
